>>> rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants for the transfer rate window estimator
// Widths, opcodes, state encodings and small helpers used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 64;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = CNT_W + 1;

  // payload widths
  localparam int OP_W     = 2;
  localparam int ADD_W    = 32;
  localparam int POS_W    = 48;
  localparam int TIME_W   = 48;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SCALE_W  = 10;
  localparam int MUL_W    = POS_W + SCALE_W;
  localparam int SPEED_W  = MUL_W + 1;
  localparam int SECS_W   = POS_W + 1;
  localparam int DCNT_W   = $clog2(MUL_W + 1);

  // configuration
  localparam int SPAN_CFG_W = 16;
  localparam int MIN_SMP_W  = 7;
  localparam int THRESH_W   = SPAN_CFG_W + SCALE_W + 1;
  localparam int CMP_W      = (CNT_W > MIN_SMP_W) ? CNT_W : MIN_SMP_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [SCALE_W-1:0]    MS_PER_SEC   = 10'd1000;
  localparam logic [SPAN_CFG_W-1:0] MIN_SPAN_RST = 16'd15;
  localparam logic [MIN_SMP_W-1:0]  MIN_SMP_RST  = 7'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_SPD,
    ST_SECS,
    ST_SECS_DIV,
    ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_PRUNE,
    WS_UPDATE,
    WS_READ,
    WS_EVAL
  } win_state_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } win_cmd_t;

  typedef struct packed {
    logic              done;
    logic              valid;
    logic              neg;
    logic [POS_W-1:0]  mag;
    logic [TIME_W-1:0] span;
  } win_status_t;

  // (base + off) mod depth, off never above the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(WINDOW_DEPTH)) begin
      sum = sum - SUM_W'(WINDOW_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // span in ms at which span / 1000 exceeds the configured seconds
  function automatic logic [THRESH_W-1:0] span_thresh(input logic [SPAN_CFG_W-1:0] secs);
    logic [THRESH_W-1:0] s;
    s = THRESH_W'(secs) + THRESH_W'(1);
    return s * THRESH_W'(MS_PER_SEC);
  endfunction

endpackage

`default_nettype wire

>>> rtl/tre_sdiv.sv
// ----------------------------------------------------------------------------
// tre_sdiv: bit-serial restoring divider
// One quotient bit per cycle; the dividend shifts out of the top of the
// quotient register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_sdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tre_pkg::MUL_W-1:0] dividend,
  input  logic [tre_pkg::MUL_W-1:0] divisor,
  output logic                      done,
  output logic [tre_pkg::MUL_W-1:0] quotient
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [tre_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [tre_pkg::MUL_W-1:0]  rem_r, rem_nxt;
  logic [tre_pkg::MUL_W-1:0]  quo_r, quo_nxt;
  logic [tre_pkg::MUL_W-1:0]  dvs_r, dvs_nxt;

  logic [tre_pkg::MUL_W:0] trial;
  logic [tre_pkg::MUL_W:0] diff;
  logic                    fits;

  assign trial = {rem_r, quo_r[tre_pkg::MUL_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tre_pkg::DCNT_W'(tre_pkg::MUL_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[tre_pkg::MUL_W-1:0] : trial[tre_pkg::MUL_W-1:0];
      quo_nxt = {quo_r[tre_pkg::MUL_W-2:0], fits};
      cnt_nxt = cnt_r - tre_pkg::DCNT_W'(1);
      if (cnt_r == tre_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // a new division never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r)
    else $error("divider finished without done");

endmodule

`default_nettype wire

>>> rtl/tre_window.sv
// ----------------------------------------------------------------------------
// tre_window: ring of (time, position) samples
// Runs the prune / update / append sequence of a tick and reports the window
// span and position delta taken between the oldest and newest samples.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tre_pkg::win_cmd_t              cmd,
  input  logic [tre_pkg::TIME_W-1:0]     now_ms,
  input  logic [tre_pkg::POS_W-1:0]      byte_pos,
  input  logic [tre_pkg::THRESH_W-1:0]   thresh,
  input  logic [tre_pkg::MIN_SMP_W-1:0]  min_smp,
  output tre_pkg::win_status_t           status
);

  logic [tre_pkg::TIME_W-1:0] times_mem [tre_pkg::WINDOW_DEPTH];
  logic [tre_pkg::POS_W-1:0]  pos_mem   [tre_pkg::WINDOW_DEPTH];

  tre_pkg::win_state_t       state_r, state_nxt;
  logic [tre_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [tre_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [tre_pkg::TIME_W-1:0] now_r, now_nxt;
  logic                      prune_r, prune_nxt;
  logic                      match_r, match_nxt;
  tre_pkg::win_status_t      status_r, status_nxt;

  logic [tre_pkg::TIME_W-1:0] t_old_r, t_new_r;
  logic [tre_pkg::POS_W-1:0]  p_old_r, p_new_r;

  logic [tre_pkg::IDX_W-1:0]  newest;
  logic                       mem_we;
  logic [tre_pkg::IDX_W-1:0]  wr_idx;

  logic [tre_pkg::DIFF_W-1:0] span_d;
  logic [tre_pkg::CMP_W-1:0]  cnt_x, ms_x;
  logic [tre_pkg::CNT_W-1:0]  drop;
  logic [tre_pkg::IDX_W-1:0]  head_p, head_a;
  logic [tre_pkg::CNT_W-1:0]  count_p, count_a;
  logic                       pos_ge;

  assign newest = (count_r == '0) ? head_r :
                  tre_pkg::wrap_idx(head_r, count_r - tre_pkg::CNT_W'(1));

  // reads always follow the live head and newest slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      times_mem[wr_idx] <= now_r;
      pos_mem[wr_idx]   <= byte_pos;
    end
    t_old_r <= times_mem[head_r];
    t_new_r <= times_mem[newest];
    p_old_r <= pos_mem[head_r];
    p_new_r <= pos_mem[newest];
  end

  always_comb begin
    span_d = {1'b0, t_new_r} - {1'b0, t_old_r};
    pos_ge = (p_new_r >= p_old_r);
    cnt_x  = tre_pkg::CMP_W'(count_r);
    ms_x   = tre_pkg::CMP_W'(min_smp);
    if (!prune_r) begin
      drop = '0;
    end else if (ms_x == '0) begin
      drop = count_r;
    end else if (cnt_x >= ms_x) begin
      drop = tre_pkg::CNT_W'(cnt_x - ms_x + tre_pkg::CMP_W'(1));
    end else begin
      drop = '0;
    end
    head_p  = tre_pkg::wrap_idx(head_r, drop);
    count_p = count_r - drop;
    // full ring loses its oldest sample before the append
    if (count_p == tre_pkg::CNT_W'(tre_pkg::WINDOW_DEPTH)) begin
      head_a  = tre_pkg::wrap_idx(head_p, tre_pkg::CNT_W'(1));
      count_a = count_p - tre_pkg::CNT_W'(1);
    end else begin
      head_a  = head_p;
      count_a = count_p;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    now_nxt         = now_r;
    prune_nxt       = prune_r;
    match_nxt       = match_r;
    status_nxt      = status_r;
    status_nxt.done = 1'b0;
    mem_we          = 1'b0;
    wr_idx          = head_r;
    unique case (state_r)
      tre_pkg::WS_IDLE: begin
        if (cmd.clear) begin
          head_nxt  = '0;
          count_nxt = '0;
        end else if (cmd.tick) begin
          now_nxt   = now_ms;
          state_nxt = tre_pkg::WS_PRUNE;
        end
      end
      tre_pkg::WS_PRUNE: begin
        prune_nxt = (count_r != '0) && !span_d[tre_pkg::DIFF_W-1] &&
                    (span_d >= tre_pkg::DIFF_W'(thresh));
        match_nxt = (p_new_r == byte_pos);
        state_nxt = tre_pkg::WS_UPDATE;
      end
      tre_pkg::WS_UPDATE: begin
        mem_we = 1'b1;
        if ((count_p > tre_pkg::CNT_W'(1)) && match_r) begin
          // position unchanged: refresh the newest time only
          wr_idx    = newest;
          head_nxt  = head_p;
          count_nxt = count_p;
        end else begin
          wr_idx    = tre_pkg::wrap_idx(head_a, count_a);
          head_nxt  = head_a;
          count_nxt = count_a + tre_pkg::CNT_W'(1);
        end
        state_nxt = tre_pkg::WS_READ;
      end
      tre_pkg::WS_READ: begin
        state_nxt = tre_pkg::WS_EVAL;
      end
      tre_pkg::WS_EVAL: begin
        status_nxt.done  = 1'b1;
        status_nxt.valid = (count_r >= tre_pkg::CNT_W'(2)) &&
                           !span_d[tre_pkg::DIFF_W-1] && (span_d != '0);
        status_nxt.neg   = !pos_ge;
        status_nxt.mag   = pos_ge ? (p_new_r - p_old_r) : (p_old_r - p_new_r);
        status_nxt.span  = span_d[tre_pkg::TIME_W-1:0];
        state_nxt        = tre_pkg::WS_IDLE;
      end
      default: begin
        state_nxt = tre_pkg::WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tre_pkg::WS_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      status_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
    now_r   <= now_nxt;
    prune_r <= prune_nxt;
    match_r <= match_nxt;
  end

  assign status = status_r;

  a_tick_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick || cmd.clear) |-> (state_r == tre_pkg::WS_IDLE))
    else $error("window command during a tick");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tre_pkg::CNT_W'(tre_pkg::WINDOW_DEPTH))
    else $error("window count above depth");

  a_valid_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r.done && status_r.valid) |-> (count_r >= tre_pkg::CNT_W'(2)))
    else $error("speed reported with fewer than two samples");

endmodule

`default_nettype wire

>>> rtl/transfer_rate_window_estimator.sv
// ----------------------------------------------------------------------------
// transfer_rate_window_estimator: windowed transfer speed and time left
// Accumulates byte counts, samples (time, position) on ticks and reports the
// average speed over the window and the seconds left to a given size.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item (add bytes, tick, reset); accepted when in_valid
//           is high and in_stall low. One item is worked on at a time.
//   out_* : one result beat per item, held in an output register until taken.
//   cfg_* : register writes (index 0 span seconds, 1 minimum samples); always
//           ready, to be written only while no item is in flight.
// Sequence: add, clear or an unused opcode go straight to the time-left step;
//   a tick first runs the window sequence, then the speed division when there
//   are two samples or more and a positive span. The time-left division runs
//   only when the speed is positive, in the same serial divider as the speed.
//   A new beat is taken the cycle after the result is registered.
// Stall: a stalled result holds; the next item runs but waits to be shown.
// Reset: position, totals and window empty, registers back to 15 and 15.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_rate_window_estimator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tre_pkg::OP_W-1:0]             in_opcode,
  input  logic [tre_pkg::ADD_W-1:0]            in_byte_count,
  input  logic [tre_pkg::ADD_W-1:0]            in_actual_count,
  input  logic [tre_pkg::TIME_W-1:0]           in_now_ms,
  input  logic [tre_pkg::POS_W-1:0]            in_total_size,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tre_pkg::POS_W-1:0]            out_position,
  output logic [tre_pkg::POS_W-1:0]            out_actual_total,
  output logic signed [tre_pkg::SPEED_W-1:0]   out_average_speed,
  output logic signed [tre_pkg::SECS_W-1:0]    out_seconds_left,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tre_pkg::CFG_DATA_W-1:0]       cfg_data
);

  tre_pkg::top_state_t          state_r, state_nxt;
  logic [tre_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [tre_pkg::POS_W-1:0]    act_r, act_nxt;
  logic [tre_pkg::POS_W-1:0]    total_r, total_nxt;
  logic [tre_pkg::SPEED_W-1:0]  speed_r, speed_nxt;
  logic [tre_pkg::SECS_W-1:0]   secs_r, secs_nxt;
  logic                         neg_r, neg_nxt;
  logic [tre_pkg::THRESH_W-1:0] thresh_r;
  logic [tre_pkg::MIN_SMP_W-1:0] min_smp_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [tre_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [tre_pkg::POS_W-1:0]    out_act_r, out_act_nxt;
  logic [tre_pkg::SPEED_W-1:0]  out_speed_r, out_speed_nxt;
  logic [tre_pkg::SECS_W-1:0]   out_secs_r, out_secs_nxt;

  logic                         accept;
  tre_pkg::win_cmd_t            win_cmd;
  tre_pkg::win_status_t         win_st;

  logic                         div_start;
  logic [tre_pkg::MUL_W-1:0]    div_dvd, div_dvs, div_quo;
  logic                         div_done;

  logic                         speed_pos;
  logic                         left_ge;
  logic [tre_pkg::POS_W-1:0]    left_mag;
  logic [tre_pkg::MUL_W-1:0]    mag_ext;

  assign in_stall  = (state_r != tre_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign win_cmd.tick  = accept && (in_opcode == tre_pkg::OP_TICK);
  assign win_cmd.clear = accept && (in_opcode == tre_pkg::OP_CLEAR);

  assign speed_pos = !speed_r[tre_pkg::SPEED_W-1] && (speed_r != '0);
  assign left_ge   = (total_r >= pos_r);
  assign left_mag  = left_ge ? (total_r - pos_r) : (pos_r - total_r);
  assign mag_ext   = tre_pkg::MUL_W'(win_st.mag);

  tre_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (win_cmd),
    .now_ms   (in_now_ms),
    .byte_pos (pos_r),
    .thresh   (thresh_r),
    .min_smp  (min_smp_r),
    .status   (win_st)
  );

  tre_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    act_nxt       = act_r;
    total_nxt     = total_r;
    speed_nxt     = speed_r;
    secs_nxt      = secs_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_act_nxt   = out_act_r;
    out_speed_nxt = out_speed_r;
    out_secs_nxt  = out_secs_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tre_pkg::ST_IDLE: begin
        if (accept) begin
          total_nxt = in_total_size;
          state_nxt = tre_pkg::ST_SECS;
          unique case (tre_pkg::opcode_t'(in_opcode))
            tre_pkg::OP_ADD: begin
              pos_nxt = pos_r + tre_pkg::POS_W'(in_byte_count);
              act_nxt = act_r + tre_pkg::POS_W'(in_actual_count);
            end
            tre_pkg::OP_TICK: begin
              state_nxt = tre_pkg::ST_WIN;
            end
            tre_pkg::OP_CLEAR: begin
              pos_nxt   = '0;
              act_nxt   = '0;
              speed_nxt = '0;
            end
            default: begin
              state_nxt = tre_pkg::ST_SECS;
            end
          endcase
        end
      end
      tre_pkg::ST_WIN: begin
        if (win_st.done) begin
          if (win_st.valid) begin
            // bytes * 1000 / span_ms, times 1000 as 1024 - 32 + 8
            div_start = 1'b1;
            div_dvd   = (mag_ext << 10) - (mag_ext << 5) + (mag_ext << 3);
            div_dvs   = tre_pkg::MUL_W'(win_st.span);
            neg_nxt   = win_st.neg;
            state_nxt = tre_pkg::ST_SPD;
          end else begin
            speed_nxt = '0;
            state_nxt = tre_pkg::ST_SECS;
          end
        end
      end
      tre_pkg::ST_SPD: begin
        if (div_done) begin
          speed_nxt = neg_r ? (tre_pkg::SPEED_W'(0) - {1'b0, div_quo}) : {1'b0, div_quo};
          state_nxt = tre_pkg::ST_SECS;
        end
      end
      tre_pkg::ST_SECS: begin
        if (speed_pos) begin
          div_start = 1'b1;
          div_dvd   = tre_pkg::MUL_W'(left_mag);
          div_dvs   = speed_r[tre_pkg::MUL_W-1:0];
          neg_nxt   = !left_ge;
          state_nxt = tre_pkg::ST_SECS_DIV;
        end else begin
          secs_nxt  = '0;
          state_nxt = tre_pkg::ST_OUT;
        end
      end
      tre_pkg::ST_SECS_DIV: begin
        if (div_done) begin
          secs_nxt  = neg_r ? (tre_pkg::SECS_W'(0) - tre_pkg::SECS_W'(div_quo)) :
                              tre_pkg::SECS_W'(div_quo);
          state_nxt = tre_pkg::ST_OUT;
        end
      end
      tre_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_act_nxt   = act_r;
          out_speed_nxt = speed_r;
          out_secs_nxt  = secs_r;
          state_nxt     = tre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tre_pkg::ST_IDLE;
      pos_r       <= '0;
      act_r       <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      act_r       <= act_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    total_r     <= total_nxt;
    secs_r      <= secs_nxt;
    neg_r       <= neg_nxt;
    out_pos_r   <= out_pos_nxt;
    out_act_r   <= out_act_nxt;
    out_speed_r <= out_speed_nxt;
    out_secs_r  <= out_secs_nxt;
  end

  // config registers; span kept as its threshold in ms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= tre_pkg::span_thresh(tre_pkg::MIN_SPAN_RST);
      min_smp_r <= tre_pkg::MIN_SMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tre_pkg::CFG_MIN_SPAN: begin
          thresh_r <= tre_pkg::span_thresh(cfg_data);
        end
        tre_pkg::CFG_MIN_SAMPLES: begin
          min_smp_r <= cfg_data[tre_pkg::MIN_SMP_W-1:0];
        end
        default: begin
          thresh_r <= thresh_r;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_actual_total  = out_act_r;
  assign out_average_speed = out_speed_r;
  assign out_seconds_left  = out_secs_r;

endmodule

`default_nettype wire

>>> bench/rate_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_window_checker: result predictor and comparator for the rate estimator
// Tracks register writes and accepted item beats, keeps its own copy of the
// sample window and counters, and compares every result beat with the oldest
// expected result. Reports the number of failures and the pending results.
// ----------------------------------------------------------------------------
module rate_window_checker import tre_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic [ADD_W-1:0]         in_byte_count,
  input  logic [ADD_W-1:0]         in_actual_count,
  input  logic [TIME_W-1:0]        in_now_ms,
  input  logic [POS_W-1:0]         in_total_size,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [POS_W-1:0]         out_position,
  input  logic [POS_W-1:0]         out_actual_total,
  input  logic [SPEED_W-1:0]       out_average_speed,
  input  logic [SECS_W-1:0]        out_seconds_left,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int unsigned              outstanding,
  output int unsigned              fail_count
);

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   actual_total;
    logic [SPEED_W-1:0] speed;
    logic [SECS_W-1:0]  secs_left;
  } rate_result_t;

  rate_result_t expected_results[$];

  logic [SPAN_CFG_W-1:0] span_limit_s;
  logic [MIN_SMP_W-1:0]  prune_floor;

  logic [TIME_W-1:0] win_time [WINDOW_DEPTH];
  logic [POS_W-1:0]  win_pos  [WINDOW_DEPTH];
  int unsigned       win_head;
  int unsigned       win_count;
  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  actual_sum;

  function automatic int unsigned slot_of(input int unsigned off);
    return (win_head + off) % WINDOW_DEPTH;
  endfunction

  function automatic longint sub48(input logic [47:0] a, input logic [47:0] b);
    return longint'({16'd0, a}) - longint'({16'd0, b});
  endfunction

  function automatic longint window_span();
    return sub48(win_time[slot_of(win_count - 1)], win_time[win_head]);
  endfunction

  function automatic void drop_oldest();
    if (win_count > 0) begin
      win_head  = (win_head + 1) % WINDOW_DEPTH;
      win_count = win_count - 1;
    end
  endfunction

  function automatic void take_sample(input logic [TIME_W-1:0] now);
    longint      span;
    int unsigned n;
    if (win_count >= 1) begin
      span = window_span();
      if (span >= 0 && (span / 1000) > longint'(span_limit_s)) begin
        while (win_count > 0 && win_count >= prune_floor) begin
          drop_oldest();
        end
      end
    end
    // position unchanged since the last sample: just slide its time
    if (win_count > 1) begin
      n = slot_of(win_count - 1);
      if (win_pos[n] == byte_pos) begin
        win_time[n] = now;
        return;
      end
    end
    if (win_count >= WINDOW_DEPTH) begin
      drop_oldest();
    end
    n = slot_of(win_count);
    win_time[n] = now;
    win_pos[n]  = byte_pos;
    win_count   = win_count + 1;
  endfunction

  function automatic longint window_speed();
    longint      span;
    longint      bytes;
    logic [63:0] mag;
    logic [63:0] q;
    if (win_count < 2) begin
      return 0;
    end
    span = window_span();
    if (span <= 0) begin
      return 0;
    end
    bytes = sub48(win_pos[slot_of(win_count - 1)], win_pos[win_head]);
    mag   = (bytes < 0) ? unsigned'(-bytes) : unsigned'(bytes);
    q     = (mag * 64'd1000) / unsigned'(span);
    return (bytes < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic rate_result_t apply_item(input logic [OP_W-1:0] op,
                                              input logic [ADD_W-1:0] add_bytes,
                                              input logic [ADD_W-1:0] add_actual,
                                              input logic [TIME_W-1:0] now,
                                              input logic [POS_W-1:0] total);
    rate_result_t res;
    longint       speed;
    longint       left;
    longint       secs;
    logic [63:0]  speed_bits;
    logic [63:0]  secs_bits;
    case (opcode_t'(op))
      OP_ADD: begin
        byte_pos   = byte_pos + POS_W'(add_bytes);
        actual_sum = actual_sum + POS_W'(add_actual);
      end
      OP_TICK: begin
        take_sample(now);
      end
      OP_CLEAR: begin
        byte_pos   = '0;
        actual_sum = '0;
        win_head   = 0;
        win_count  = 0;
      end
      default: begin
      end
    endcase
    speed      = window_speed();
    left       = sub48(total, byte_pos);
    secs       = (speed > 0) ? left / speed : 0;
    speed_bits = speed;
    secs_bits  = secs;
    res.position     = byte_pos;
    res.actual_total = actual_sum;
    res.speed        = speed_bits[SPEED_W-1:0];
    res.secs_left    = secs_bits[SECS_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rate_result_t want;
    rate_result_t next_exp;
    if (!rst_n) begin
      span_limit_s = MIN_SPAN_RST;
      prune_floor  = MIN_SMP_RST;
      win_head     = 0;
      win_count    = 0;
      byte_pos     = '0;
      actual_sum   = '0;
      fail_count   = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_SPAN:    span_limit_s = cfg_data;
          CFG_MIN_SAMPLES: prune_floor  = cfg_data[MIN_SMP_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        next_exp = apply_item(in_opcode, in_byte_count, in_actual_count,
                              in_now_ms, in_total_size);
        expected_results.insert(expected_results.size(), next_exp);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) begin
            $display("%0t: result beat with no item pending", $realtime);
          end
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_position != want.position || out_actual_total != want.actual_total ||
              out_average_speed != want.speed || out_seconds_left != want.secs_left) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("%0t: mismatch pos exp %h got %h, actual exp %h got %h", $realtime,
                       want.position, out_position, want.actual_total, out_actual_total);
              $display("  speed exp %0d got %0d, secs left exp %0d got %0d",
                       $signed(want.speed), $signed(out_average_speed),
                       $signed(want.secs_left), $signed(out_seconds_left));
            end
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the transfer rate window estimator
// Drives directed and random add / tick / clear beats through several register
// settings and idling mixes, then a short run of maximum adds with ticks.
// A side checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import tre_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam int unsigned     CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned     SETTLE_CYCLES = 2 * 58 + 12;
  localparam logic [47:0]     ALL_ONES_48   = 48'hFFFF_FFFF_FFFF;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_opcode = OP_ADD;
  logic [ADD_W-1:0]         in_byte_count = '0;
  logic [ADD_W-1:0]         in_actual_count = '0;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic [POS_W-1:0]         in_total_size = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [POS_W-1:0]         out_position;
  logic [POS_W-1:0]         out_actual_total;
  logic signed [SPEED_W-1:0] out_average_speed;
  logic signed [SECS_W-1:0] out_seconds_left;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [47:0] now_track = '0;
  logic [47:0] pos_track = '0;

  always #5 clk = ~clk;

  transfer_rate_window_estimator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_byte_count(in_byte_count), .in_actual_count(in_actual_count),
    .in_now_ms(in_now_ms), .in_total_size(in_total_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_position(out_position),
    .out_actual_total(out_actual_total), .out_average_speed(out_average_speed),
    .out_seconds_left(out_seconds_left),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rate_window_checker rate_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_byte_count(in_byte_count), .in_actual_count(in_actual_count),
    .in_now_ms(in_now_ms), .in_total_size(in_total_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_position(out_position),
    .out_actual_total(out_actual_total), .out_average_speed(out_average_speed),
    .out_seconds_left(out_seconds_left),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [31:0] byte_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  // sizes around the current position so time left is positive, negative or zero
  function automatic logic [47:0] pick_total();
    case ($urandom_range(0, 6))
      0:       return pos_track + $urandom_range(0, 1 << 20);
      1:       return pos_track + (48'($urandom) << $urandom_range(0, 16));
      2:       return pos_track - $urandom_range(0, 4096);
      3:       return rand48();
      4:       return pos_track;
      5:       return ALL_ONES_48;
      default: return '0;
    endcase
  endfunction

  // mostly forward steps scaled to the span setting, some big jumps and some going back
  function automatic logic [47:0] tick_time(input int unsigned span_s);
    int unsigned sel;
    int unsigned step_cap;
    sel      = $urandom_range(0, 99);
    step_cap = span_s * 1000 / 48;
    if (sel < 86) begin
      now_track = now_track + $urandom_range(0, step_cap);
    end else if (sel < 94) begin
      now_track = now_track + $urandom_range(0, span_s * 2000);
    end else if (sel < 98) begin
      return now_track - $urandom_range(1, step_cap + 1);
    end else begin
      now_track = rand48();
    end
    return now_track;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADD_W-1:0] add_bytes,
                           input logic [ADD_W-1:0] add_actual, input logic [TIME_W-1:0] now,
                           input logic [POS_W-1:0] total);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_byte_count   <= add_bytes;
    in_actual_count <= add_actual;
    in_now_ms       <= now;
    in_total_size   <= total;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (op == OP_ADD) begin
      pos_track = pos_track + 48'(add_bytes);
    end else if (op == OP_CLEAR) begin
      pos_track = '0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(input logic [15:0] span_s, input logic [15:0] floor_count,
                           input int unsigned sender_idle, input int unsigned recv_stall);
    wait_drained();
    write_reg(CFG_MIN_SPAN, span_s);
    write_reg(CFG_MIN_SAMPLES, floor_count);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    now_track = rand48();
  endtask

  // mostly add-then-tick transfers, with lone ticks, lone adds, clears and noise
  task automatic run_random(input int unsigned n_items, input int unsigned clear_pct,
                            input int unsigned span_s);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(OP_UNUSED, $urandom, $urandom, rand48(), pick_total());
        sent++;
      end else if (r < 2 + clear_pct) begin
        send_item(OP_CLEAR, $urandom, $urandom, rand48(), pick_total());
        sent++;
      end else if (r < 80) begin
        send_item(OP_ADD, byte_amount(), $urandom, rand48(), pick_total());
        send_item(OP_TICK, $urandom, $urandom, tick_time(span_s), pick_total());
        sent += 2;
      end else if (r < 90) begin
        send_item(OP_TICK, $urandom, $urandom, tick_time(span_s), pick_total());
        sent++;
      end else begin
        send_item(OP_ADD, byte_amount(), $urandom_range(0, 255), rand48(), pick_total());
        sent++;
      end
      if ($urandom_range(0, 149) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: max counts, first speed, unchanged-position tick, unused opcode
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    send_item(OP_TICK, '0, '0, '0, ALL_ONES_48);
    send_item(OP_ADD, 32'd1000, '0, ALL_ONES_48, ALL_ONES_48);
    send_item(OP_TICK, '0, '0, 48'd1000, ALL_ONES_48);
    send_item(OP_TICK, '0, '0, 48'd3000, ALL_ONES_48);
    send_item(OP_ADD, '0, 32'd1, '0, pos_track + 48'd5000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ALL_ONES_48, pos_track + 48'd7);
    send_item(OP_ADD, 32'd500, 32'd3, '0, pos_track + 48'd100_000);
    send_item(OP_TICK, '0, '0, 48'd20000, pos_track + 48'd100_000);
    // span over the limit but too few samples to prune
    send_item(OP_ADD, 32'd1, '0, '0, pos_track);
    send_item(OP_TICK, '0, '0, 48'd40000, pos_track - 48'd9);
    // time going backwards gives a negative span
    send_item(OP_CLEAR, '0, '0, '0, '0);
    send_item(OP_TICK, '0, '0, ALL_ONES_48, '0);
    send_item(OP_ADD, 32'd4096, 32'd4096, '0, 48'd1 << 30);
    send_item(OP_TICK, '0, '0, 48'd10, 48'd1 << 30);
    send_item(OP_ADD, 32'd1, '0, '0, 48'd1 << 30);
    send_item(OP_TICK, '0, '0, 48'd20, ALL_ONES_48);
    send_item(OP_UNUSED, '0, '0, '0, ALL_ONES_48);

    now_track = 48'd50_000;
    run_random(120, 3, 15);
    set_phase(16'd1, 16'd1, 45, 0);
    run_random(120, 3, 1);
    set_phase(16'hFFFF, 16'd64, 0, 45);
    run_random(260, 0, 65535);
    set_phase(16'd2, 16'd0, 17, 17);
    run_random(120, 3, 2);
    set_phase(16'd40, 16'd3, 0, 0);
    run_random(180, 4, 40);

    // maximum adds between ticks a second apart
    set_phase(16'd15, 16'd15, 0, 0);
    send_item(OP_CLEAR, '0, '0, '0, '0);
    repeat (6) begin
      send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, ALL_ONES_48);
    end
    send_item(OP_TICK, '0, '0, now_track, ALL_ONES_48);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, ALL_ONES_48);
    send_item(OP_TICK, '0, '0, now_track + 48'd1000, ALL_ONES_48);
    send_item(OP_ADD, 32'd77, '0, '0, pos_track + 48'd1000);
    send_item(OP_TICK, '0, '0, now_track + 48'd2000, '0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
